FILE: rtl/core/ubn_pkg.sv
// ----------------------------------------------------------------------------
// ubn_pkg
// Shared types and constants of the unit box normalizer.
// ----------------------------------------------------------------------------
package ubn_pkg;

  localparam int unsigned SCALE_BITS = 25;
  localparam int unsigned STEP_BITS  = $clog2(SCALE_BITS);
  localparam int unsigned NUM_AXES   = 3;
  localparam int unsigned AXIS_BITS  = $clog2(NUM_AXES);
  localparam int unsigned ACT_BITS   = 2;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_SCALE   = 2'd2
  } action_e;

  typedef struct packed {
    logic clear;
    logic measure;
  } box_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/ubn_in_if.sv
// ----------------------------------------------------------------------------
// ubn_in_if
// Input channel: action code and one vertex per transfer.
// ----------------------------------------------------------------------------
interface ubn_in_if import ubn_pkg::*; #(
  parameter int unsigned COORD_BITS = 32
) ();
  logic                  valid;
  logic                  ready;
  logic [ACT_BITS-1:0]   action;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  logic [COORD_BITS-1:0] coord_z;

  modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
  modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

FILE: rtl/core/ubn_out_if.sv
// ----------------------------------------------------------------------------
// ubn_out_if
// Output channel: normalized vertex and status per transfer.
// ----------------------------------------------------------------------------
interface ubn_out_if import ubn_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SCALE_BITS-1:0] norm_x;
  logic [SCALE_BITS-1:0] norm_y;
  logic [SCALE_BITS-1:0] norm_z;
  logic                  status;

  modport source (output valid, norm_x, norm_y, norm_z, status, input ready);
  modport sink   (input valid, norm_x, norm_y, norm_z, status, output ready);
endinterface

FILE: rtl/core/ubn_box.sv
// ----------------------------------------------------------------------------
// ubn_box
// Running per-axis bounding box with extent lanes.
// ----------------------------------------------------------------------------
module ubn_box import ubn_pkg::*; #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  box_ctl_t                     ctl_i,
  input  logic signed [COORD_BITS-1:0] coord_i [NUM_AXES],
  output logic signed [COORD_BITS-1:0] min_o   [NUM_AXES],
  output logic [COORD_BITS-1:0]        ext_o   [NUM_AXES],
  output logic                         seen_o
);

  localparam logic signed [COORD_BITS-1:0] MostPos = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] MostNeg = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic signed [COORD_BITS-1:0] min_q [NUM_AXES];
  logic signed [COORD_BITS-1:0] max_q [NUM_AXES];
  logic                         seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        min_q[a] <= MostPos;
        max_q[a] <= MostNeg;
      end
      seen_q <= 1'b0;
    end else if (ctl_i.clear) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        min_q[a] <= MostPos;
        max_q[a] <= MostNeg;
      end
      seen_q <= 1'b0;
    end else if (ctl_i.measure) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        if (coord_i[a] < min_q[a]) min_q[a] <= coord_i[a];
        if (coord_i[a] > max_q[a]) max_q[a] <= coord_i[a];
      end
      seen_q <= 1'b1;
    end
  end

  logic signed [COORD_BITS:0] span [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      span[a]  = {max_q[a][COORD_BITS-1], max_q[a]} - {min_q[a][COORD_BITS-1], min_q[a]};
      ext_o[a] = (max_q[a] > min_q[a]) ? span[a][COORD_BITS-1:0] : '0;
      min_o[a] = min_q[a];
    end
  end

  assign seen_o = seen_q;

endmodule

FILE: rtl/core/ubn_div.sv
// ----------------------------------------------------------------------------
// ubn_div
// Radix-2 scaled divider: floor(d * s / dm), one bit of s per cycle.
// ----------------------------------------------------------------------------
module ubn_div import ubn_pkg::*; #(
  parameter int unsigned COORD_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COORD_BITS-1:0] d_i,
  input  logic [COORD_BITS-1:0] dm_i,
  input  logic [SCALE_BITS-1:0] s_i,
  output div_stat_t             stat_o,
  output logic [SCALE_BITS-1:0] q_o
);

  logic [COORD_BITS-1:0] d_q, dm_q, r_q, r_d;
  logic [SCALE_BITS-1:0] s_q, q_q, q_d;
  logic [STEP_BITS-1:0]  cnt_q;
  logic                  busy_q, done_q;

  logic [COORD_BITS:0]   r1, r1s, r2, r2s;
  logic                  c1, c2;

  always_comb begin
    r1  = {r_q, 1'b0};
    c1  = r1 >= {1'b0, dm_q};
    r1s = c1 ? r1 - {1'b0, dm_q} : r1;
    r2  = s_q[cnt_q] ? r1s + {1'b0, d_q} : r1s;
    c2  = r2 >= {1'b0, dm_q};
    r2s = c2 ? r2 - {1'b0, dm_q} : r2;
    r_d = r2s[COORD_BITS-1:0];
    q_d = {q_q[SCALE_BITS-2:0], 1'b0} + SCALE_BITS'(c1) + SCALE_BITS'(c2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= STEP_BITS'(SCALE_BITS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      d_q  <= d_i;
      dm_q <= dm_i;
      s_q  <= s_i;
      r_q  <= '0;
      q_q  <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      q_q <= q_d;
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign q_o         = q_q;

endmodule

FILE: rtl/core/unit_box_normalize.sv
// ----------------------------------------------------------------------------
// unit_box_normalize
// Two-pass normalization of a vertex stream into a cube of edge target_scale.
// ----------------------------------------------------------------------------
// Usage: the host sends a clear item, then every vertex as a measure item,
// then every vertex again as a scale item. Items arrive on in_i, results
// leave on out_o as valid/ready transfers; only scale items give a result.
// A scale item runs the three axes one after another through a single
// radix-2 divider, 25 steps each plus load and unload. An empty box or an
// all-zero extent skips the divider. The divider sets the throughput. The
// result sits in an output register, so the next item is taken while a
// result still waits; if the receiver stalls, the following scale item
// holds at its last step until the register frees. cfg_we_i writes
// target_scale (unsigned Q9.16); the user must write it only while the
// block is idle, which the block itself does not enforce. Reset empties
// the box and sets target_scale to 1.0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module unit_box_normalize import ubn_pkg::*; #(
  parameter int unsigned COORD_BITS    = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SCALE_BITS-1:0] cfg_wdata_i,
  ubn_in_if.sink                in_i,
  ubn_out_if.source             out_o
);

  localparam logic [SCALE_BITS-1:0] ScaleReset = SCALE_BITS'(1) << FRACTION_BITS;
  localparam logic [AXIS_BITS-1:0]  LastAxis   = AXIS_BITS'(NUM_AXES - 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_EXT  = 6'b000010,
    S_MAX  = 6'b000100,
    S_DIFF = 6'b001000,
    S_DIV  = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SCALE_BITS-1:0]        scale_q;
  logic signed [COORD_BITS-1:0] coord_q  [NUM_AXES];
  logic signed [COORD_BITS-1:0] coord_in [NUM_AXES];
  logic signed [COORD_BITS-1:0] box_min  [NUM_AXES];
  logic [COORD_BITS-1:0]        box_ext  [NUM_AXES];
  logic [COORD_BITS-1:0]        ext_q    [NUM_AXES];
  logic                         box_seen;
  logic [COORD_BITS-1:0]        dm_q, dm_d;
  logic [AXIS_BITS-1:0]         ax_q;
  logic [SCALE_BITS-1:0]        norm_q   [NUM_AXES];
  logic                         stat_q;

  logic [SCALE_BITS-1:0]        out_norm_q [NUM_AXES];
  logic                         out_stat_q, out_valid_q;

  box_ctl_t                     box_ctl;
  div_stat_t                    div_stat;
  logic                         div_start;
  logic [COORD_BITS-1:0]        div_d;
  logic [SCALE_BITS-1:0]        div_q;
  logic signed [COORD_BITS:0]   diff;
  logic                         in_xfer, out_free;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign coord_in[0] = in_i.coord_x;
  assign coord_in[1] = in_i.coord_y;
  assign coord_in[2] = in_i.coord_z;

  always_comb begin
    box_ctl.clear   = 1'b0;
    box_ctl.measure = 1'b0;
    if (in_xfer) begin
      unique case (action_e'(in_i.action))
        ACT_CLEAR:   box_ctl.clear   = 1'b1;
        ACT_MEASURE: box_ctl.measure = 1'b1;
        default: ;
      endcase
    end
  end

  ubn_box #(.COORD_BITS(COORD_BITS)) u_box (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (box_ctl),
    .coord_i (coord_in),
    .min_o   (box_min),
    .ext_o   (box_ext),
    .seen_o  (box_seen)
  );

  // p - min clamped to [0, dm]
  always_comb begin
    diff  = {coord_q[ax_q][COORD_BITS-1], coord_q[ax_q]}
          - {box_min[ax_q][COORD_BITS-1], box_min[ax_q]};
    div_d = (coord_q[ax_q] > box_min[ax_q]) ? diff[COORD_BITS-1:0] : '0;
    if (div_d > dm_q) div_d = dm_q;
  end

  assign div_start = (state_q == S_DIFF);

  ubn_div #(.COORD_BITS(COORD_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .d_i     (div_d),
    .dm_i    (dm_q),
    .s_i     (scale_q),
    .stat_o  (div_stat),
    .q_o     (div_q)
  );

  always_comb begin
    dm_d = ext_q[0];
    if (ext_q[1] > dm_d) dm_d = ext_q[1];
    if (ext_q[2] > dm_d) dm_d = ext_q[2];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_xfer && action_e'(in_i.action) == ACT_SCALE) state_d = S_EXT;
      S_EXT:  state_d = S_MAX;
      S_MAX:  state_d = (!box_seen || dm_d == '0) ? S_FIN : S_DIFF;
      S_DIFF: state_d = S_DIV;
      S_DIV: begin
        if (div_stat.done) state_d = (ax_q == LastAxis) ? S_FIN : S_DIFF;
      end
      S_FIN:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      scale_q     <= ScaleReset;
      out_valid_q <= 1'b0;
      ax_q        <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) scale_q <= cfg_wdata_i;
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_MAX) begin
        ax_q <= '0;
      end else if (state_q == S_DIV && div_stat.done && ax_q != LastAxis) begin
        ax_q <= ax_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      for (int a = 0; a < NUM_AXES; a++) coord_q[a] <= coord_in[a];
    end
    if (state_q == S_EXT) begin
      for (int a = 0; a < NUM_AXES; a++) ext_q[a] <= box_ext[a];
    end
    if (state_q == S_MAX) begin
      dm_q   <= dm_d;
      stat_q <= !box_seen || dm_d == '0;
      for (int a = 0; a < NUM_AXES; a++) norm_q[a] <= '0;
    end
    if (state_q == S_DIV && div_stat.done) norm_q[ax_q] <= div_q;
    if (state_q == S_FIN && out_free) begin
      for (int a = 0; a < NUM_AXES; a++) out_norm_q[a] <= norm_q[a];
      out_stat_q <= stat_q;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.norm_x = out_norm_q[0];
  assign out_o.norm_y = out_norm_q[1];
  assign out_o.norm_z = out_norm_q[2];
  assign out_o.status = out_stat_q;

  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> state_q == S_DIV)
    else $error("divider finished outside of divide state");

  a_axis_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ax_q <= LastAxis)
    else $error("axis index out of range");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stat_q |->
      out_norm_q[0] == '0 && out_norm_q[1] == '0 && out_norm_q[2] == '0)
    else $error("degenerate result with nonzero coordinates");

  a_norm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_stat_q |->
      out_norm_q[0] <= scale_q && out_norm_q[1] <= scale_q && out_norm_q[2] <= scale_q)
    else $error("normalized coordinate above target scale");

  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule
